[rtl/scyb_pkg.sv]
// Package with the shared types, colour weights and the divide-by-255 helper.
`default_nettype none

package scyb_pkg;

   localparam logic Opcode_Luma   = 1'b0;
   localparam logic Opcode_Chroma = 1'b1;

   localparam int SumWidth = 20;

   localparam logic signed [SumWidth-1:0] WeightYR = 20'sd263;
   localparam logic signed [SumWidth-1:0] WeightYG = 20'sd516;
   localparam logic signed [SumWidth-1:0] WeightYB = 20'sd100;
   localparam logic signed [SumWidth-1:0] WeightUR = 20'sd450;
   localparam logic signed [SumWidth-1:0] WeightUG = 20'sd376;
   localparam logic signed [SumWidth-1:0] WeightUB = 20'sd73;
   localparam logic signed [SumWidth-1:0] WeightVR = 20'sd152;
   localparam logic signed [SumWidth-1:0] WeightVG = 20'sd298;
   localparam logic signed [SumWidth-1:0] WeightVB = 20'sd450;

   localparam logic [7:0] OffsetLuma   = 8'd16;
   localparam logic [7:0] OffsetChroma = 8'd128;
   localparam logic [7:0] FullScale    = 8'd255;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

   // Exact floor(x / 255) for x up to 255 * 255, by reciprocal and one correction.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [23:0] scaled;
      logic [7:0]  quot;
      logic [15:0] back;
      logic [15:0] rem;
      scaled = {x, 8'b0} + {8'b0, x};
      quot   = scaled[23:16];
      back   = {quot, 8'b0} - {8'b0, quot};
      rem    = x - back;
      if (rem >= {8'b0, FullScale}) begin
         quot = quot + 8'd1;
      end
      return quot;
   endfunction

endpackage

`default_nettype wire

[rtl/scyb_color.sv]
// Two-stage conversion of an RGBA colour to 8-bit Y, U and V samples.
`default_nettype none

module scyb_color (
   input  wire logic              clock,
   input  wire logic [31:0]       color_rgba,
   output scyb_pkg::yuv_type      yuv
);
   import scyb_pkg::*;

   logic signed [SumWidth-1:0] red;
   logic signed [SumWidth-1:0] green;
   logic signed [SumWidth-1:0] blue;
   logic signed [SumWidth-1:0] sum_y_in, sum_y_ff;
   logic signed [SumWidth-1:0] sum_u_in, sum_u_ff;
   logic signed [SumWidth-1:0] sum_v_in, sum_v_ff;
   yuv_type                    yuv_in, yuv_ff;

   assign red   = {12'b0, color_rgba[31:24]};
   assign green = {12'b0, color_rgba[23:16]};
   assign blue  = {12'b0, color_rgba[15:8]};

   assign sum_y_in = WeightYR * red + WeightYG * green + WeightYB * blue;
   assign sum_u_in = WeightUR * red - WeightUG * green - WeightUB * blue;
   assign sum_v_in = WeightVB * blue - WeightVR * red - WeightVG * green;

   // The low byte of a floor shift by ten is bits 17 to 10 of the sum.
   always_comb begin
      yuv_in.y = sum_y_ff[17:10] + OffsetLuma;
      yuv_in.u = sum_u_ff[17:10] + OffsetChroma;
      yuv_in.v = sum_v_ff[17:10] + OffsetChroma;
   end

   always_ff @(posedge clock) begin
      sum_y_ff <= sum_y_in;
      sum_u_ff <= sum_u_in;
      sum_v_ff <= sum_v_in;
      yuv_ff   <= yuv_in;
   end

   assign yuv = yuv_ff;

endmodule

`default_nettype wire

[rtl/subtitle_coverage_yuv_blend.sv]
// Top level of the subtitle coverage blend onto YUV 4:2:0 samples.
// The block takes one request in every clock cycle and busy stays low. Each
// request gives its result on the rsp_ ports, marked by rsp_valid, after it
// has passed through the five register stages of the blend pipeline, and the
// receiver cannot hold results off.
`default_nettype none

module subtitle_coverage_yuv_blend (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output wire logic        busy,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_color_rgba,
   input  wire logic [7:0]  req_cover_a,
   input  wire logic [7:0]  req_cover_b,
   input  wire logic [7:0]  req_cover_c,
   input  wire logic [7:0]  req_cover_d,
   input  wire logic [7:0]  req_orig_luma,
   input  wire logic [7:0]  req_orig_cb,
   input  wire logic [7:0]  req_orig_cr,
   output wire logic        rsp_valid,
   output wire logic [7:0]  rsp_new_luma,
   output wire logic [7:0]  rsp_new_cb,
   output wire logic [7:0]  rsp_new_cr
);
   import scyb_pkg::*;

   logic        accept;
   logic [9:0]  cover_sum;
   yuv_type     yuv;

   logic        v1_in, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic        op1_ff, op2_ff, op3_ff, op4_ff;
   logic [7:0]  cov1_in, cov1_ff;
   logic [7:0]  opac1_ff;
   logic [7:0]  oy1_ff, ou1_ff, ov1_ff;
   logic [7:0]  oy2_ff, ou2_ff, ov2_ff;
   logic [7:0]  oy3_ff, ou3_ff, ov3_ff;
   logic [7:0]  oy4_ff, ou4_ff, ov4_ff;
   logic [15:0] prod2_in, prod2_ff;
   logic [7:0]  k3_ff;
   logic [7:0]  ca3_in, ca3_ff, oa3_in, oa3_ff;
   logic [7:0]  cb3_ff, ob3_ff;
   logic [15:0] sa4_in, sa4_ff, sb4_in, sb4_ff;
   logic [7:0]  qa5, qb5;
   logic [7:0]  luma5_in, luma5_ff, cb5_in, cb5_ff, cr5_in, cr5_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign v1_in  = accept;

   scyb_color u_color (
      .clock      (clock),
      .color_rgba (req_color_rgba),
      .yuv        (yuv)
   );

   assign cover_sum = {2'b0, req_cover_a} + {2'b0, req_cover_b}
                    + {2'b0, req_cover_c} + {2'b0, req_cover_d};
   assign cov1_in   = (req_opcode == Opcode_Chroma) ? cover_sum[9:2] : req_cover_a;

   assign prod2_in = {8'b0, cov1_ff} * {8'b0, opac1_ff};

   assign ca3_in = (op2_ff == Opcode_Chroma) ? yuv.u  : yuv.y;
   assign oa3_in = (op2_ff == Opcode_Chroma) ? ou2_ff : oy2_ff;

   assign sa4_in = {8'b0, k3_ff} * {8'b0, ca3_ff}
                 + {8'b0, FullScale - k3_ff} * {8'b0, oa3_ff};
   assign sb4_in = {8'b0, k3_ff} * {8'b0, cb3_ff}
                 + {8'b0, FullScale - k3_ff} * {8'b0, ob3_ff};

   assign qa5 = div255(sa4_ff);
   assign qb5 = div255(sb4_ff);

   always_comb begin
      if (op4_ff == Opcode_Chroma) begin
         luma5_in = oy4_ff;
         cb5_in   = qa5;
         cr5_in   = qb5;
      end else begin
         luma5_in = qa5;
         cb5_in   = ou4_ff;
         cr5_in   = ov4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= req_opcode;
      cov1_ff  <= cov1_in;
      opac1_ff <= FullScale - req_color_rgba[7:0];
      oy1_ff   <= req_orig_luma;
      ou1_ff   <= req_orig_cb;
      ov1_ff   <= req_orig_cr;

      op2_ff   <= op1_ff;
      prod2_ff <= prod2_in;
      oy2_ff   <= oy1_ff;
      ou2_ff   <= ou1_ff;
      ov2_ff   <= ov1_ff;

      op3_ff   <= op2_ff;
      k3_ff    <= div255(prod2_ff);
      ca3_ff   <= ca3_in;
      oa3_ff   <= oa3_in;
      cb3_ff   <= yuv.v;
      ob3_ff   <= ov2_ff;
      oy3_ff   <= oy2_ff;
      ou3_ff   <= ou2_ff;
      ov3_ff   <= ov2_ff;

      op4_ff   <= op3_ff;
      sa4_ff   <= sa4_in;
      sb4_ff   <= sb4_in;
      oy4_ff   <= oy3_ff;
      ou4_ff   <= ou3_ff;
      ov4_ff   <= ov3_ff;

      luma5_ff <= luma5_in;
      cb5_ff   <= cb5_in;
      cr5_ff   <= cr5_in;
   end

   assign rsp_valid    = v5_ff;
   assign rsp_new_luma = luma5_ff;
   assign rsp_new_cb   = cb5_ff;
   assign rsp_new_cr   = cr5_ff;

endmodule

`default_nettype wire

[sim/blend_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the blended samples of each request and compares them with the results.
module blend_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_color_rgba,
   input  wire logic [7:0]  req_cover_a,
   input  wire logic [7:0]  req_cover_b,
   input  wire logic [7:0]  req_cover_c,
   input  wire logic [7:0]  req_cover_d,
   input  wire logic [7:0]  req_orig_luma,
   input  wire logic [7:0]  req_orig_cb,
   input  wire logic [7:0]  req_orig_cr,
   input  wire logic        rsp_valid,
   input  wire logic [7:0]  rsp_new_luma,
   input  wire logic [7:0]  rsp_new_cb,
   input  wire logic [7:0]  rsp_new_cr,
   output int               mismatches,
   output int               outstanding
);
   import scyb_pkg::*;

   localparam int MaxReports = 10;

   yuv_type expected_yuv[$];
   int      error_total = 0;
   int      pending_total = 0;

   assign mismatches  = error_total;
   assign outstanding = pending_total;

   // The shift floors toward minus infinity, as the conversion requires.
   function automatic logic [7:0] to_video(input int weighted_sum, input int offset);
      return 8'((weighted_sum >>> 10) + offset);
   endfunction

   function automatic logic [7:0] mix(input int k, input int colour, input int orig);
      return 8'((k * colour + (255 - k) * orig) / 255);
   endfunction

   function automatic yuv_type predict_blend(
      input logic        opcode,
      input logic [31:0] rgba,
      input logic [7:0]  ca,
      input logic [7:0]  cb,
      input logic [7:0]  cc,
      input logic [7:0]  cd,
      input logic [7:0]  oy,
      input logic [7:0]  ou,
      input logic [7:0]  ov
   );
      int      r;
      int      g;
      int      b;
      int      opacity;
      int      coverage;
      int      k;
      yuv_type result;
      r        = int'(rgba[31:24]);
      g        = int'(rgba[23:16]);
      b        = int'(rgba[15:8]);
      opacity  = 255 - int'(rgba[7:0]);
      result.y = oy;
      result.u = ou;
      result.v = ov;
      if (opcode == Opcode_Luma) begin
         k        = int'(ca) * opacity / 255;
         result.y = mix(k, int'(to_video(263 * r + 516 * g + 100 * b, 16)), int'(oy));
      end else begin
         coverage = (int'(ca) + int'(cb) + int'(cc) + int'(cd)) >> 2;
         k        = coverage * opacity / 255;
         result.u = mix(k, int'(to_video(450 * r - 376 * g - 73 * b, 128)), int'(ou));
         result.v = mix(k, int'(to_video(-152 * r - 298 * g + 450 * b, 128)), int'(ov));
      end
      return result;
   endfunction

   always @(posedge clock) begin
      yuv_type want;
      if (reset) begin
         expected_yuv.delete();
      end else begin
         if (start && !busy) begin
            expected_yuv.push_back(predict_blend(req_opcode, req_color_rgba, req_cover_a,
               req_cover_b, req_cover_c, req_cover_d, req_orig_luma, req_orig_cb,
               req_orig_cr));
         end
         if (rsp_valid) begin
            if (expected_yuv.size() == 0) begin
               if (error_total < MaxReports) begin
                  $display("Unexpected result y=%0d u=%0d v=%0d at %0t.", rsp_new_luma,
                     rsp_new_cb, rsp_new_cr, $realtime);
               end
               error_total++;
            end else begin
               want = expected_yuv.pop_front();
               if (want.y !== rsp_new_luma || want.u !== rsp_new_cb
                     || want.v !== rsp_new_cr) begin
                  if (error_total < MaxReports) begin
                     $display("Mismatch at %0t: expected y=%0d u=%0d v=%0d, got y=%0d u=%0d v=%0d.",
                        $realtime, want.y, want.u, want.v, rsp_new_luma, rsp_new_cb,
                        rsp_new_cr);
                  end
                  error_total++;
               end
            end
         end
      end
      pending_total = expected_yuv.size();
   end

endmodule

[sim/tb_subtitle_coverage_yuv_blend.sv]
`timescale 1ns / 1ps
// Testbench top that drives blend requests in bursts and gives the verdict.
module tb_subtitle_coverage_yuv_blend;
   import scyb_pkg::*;

   localparam int RandomRequests = 800;
   localparam int StallLimit     = 500;
   localparam int SettleCycles   = 10;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        req_opcode     = Opcode_Luma;
   logic [31:0] req_color_rgba = '0;
   logic [7:0]  req_cover_a    = '0;
   logic [7:0]  req_cover_b    = '0;
   logic [7:0]  req_cover_c    = '0;
   logic [7:0]  req_cover_d    = '0;
   logic [7:0]  req_orig_luma  = '0;
   logic [7:0]  req_orig_cb    = '0;
   logic [7:0]  req_orig_cr    = '0;
   wire logic       busy;
   wire logic       rsp_valid;
   wire logic [7:0] rsp_new_luma;
   wire logic [7:0] rsp_new_cb;
   wire logic [7:0] rsp_new_cr;
   int          mismatches;
   int          outstanding;
   int          quiet_cycles = 0;

   subtitle_coverage_yuv_blend dut (.*);

   blend_checker checker_inst (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_subtitle_coverage_yuv_blend failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_blend(
      input logic        opcode,
      input logic [31:0] rgba,
      input logic [7:0]  ca,
      input logic [7:0]  cb,
      input logic [7:0]  cc,
      input logic [7:0]  cd,
      input logic [7:0]  oy,
      input logic [7:0]  ou,
      input logic [7:0]  ov
   );
      @(negedge clock);
      start          <= 1'b1;
      req_opcode     <= opcode;
      req_color_rgba <= rgba;
      req_cover_a    <= ca;
      req_cover_b    <= cb;
      req_cover_c    <= cc;
      req_cover_d    <= cd;
      req_orig_luma  <= oy;
      req_orig_cb    <= ou;
      req_orig_cr    <= ov;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_cover();
      case ($urandom_range(0, 7))
         0: begin
            return 8'd0;
         end
         1: begin
            return 8'd255;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic send_random_blend();
      logic [31:0] rgba;
      logic        opcode;
      rgba   = $urandom;
      opcode = $urandom_range(0, 1) ? Opcode_Chroma : Opcode_Luma;
      case ($urandom_range(0, 5))
         0: begin
            rgba[7:0] = 8'd0;
         end
         1: begin
            rgba[7:0] = 8'd255;
         end
         default: begin
         end
      endcase
      send_blend(opcode, rgba, pick_cover(), pick_cover(), pick_cover(), pick_cover(),
         8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int sent;
      int burst;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_blend(Opcode_Luma, 32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_blend(Opcode_Luma, 32'hFFFF_FF00, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_blend(Opcode_Luma, 32'h0000_0000, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255,
         8'd255);
      send_blend(Opcode_Luma, 32'hFF00_00FF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd77, 8'd9,
         8'd200);
      send_blend(Opcode_Luma, 32'h1234_5600, 8'd0, 8'd255, 8'd255, 8'd255, 8'd40, 8'd50,
         8'd60);
      send_blend(Opcode_Luma, 32'h8080_8040, 8'd128, 8'd1, 8'd2, 8'd3, 8'd128, 8'd128,
         8'd128);
      send_blend(Opcode_Luma, 32'hFFFF_FFFF, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
      send_blend(Opcode_Luma, 32'h0000_FFFE, 8'd1, 8'd0, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0);
      send_blend(Opcode_Chroma, 32'hFF00_0000, 8'd255, 8'd255, 8'd255, 8'd255, 8'd10,
         8'd0, 8'd255);
      send_blend(Opcode_Chroma, 32'h00FF_0000, 8'd255, 8'd255, 8'd255, 8'd255, 8'd20,
         8'd255, 8'd0);
      send_blend(Opcode_Chroma, 32'h0000_FF00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd30,
         8'd0, 8'd0);
      send_blend(Opcode_Chroma, 32'hFFFF_FF00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
         8'd255, 8'd255);
      send_blend(Opcode_Chroma, 32'h0000_0000, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
         8'd128, 8'd128);
      send_blend(Opcode_Chroma, 32'hFFFF_00FF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1,
         8'd2, 8'd3);
      send_blend(Opcode_Chroma, 32'hFF00_0000, 8'd1, 8'd1, 8'd1, 8'd0, 8'd5, 8'd60,
         8'd70);
      send_blend(Opcode_Chroma, 32'h00FF_0000, 8'd255, 8'd255, 8'd255, 8'd254, 8'd5,
         8'd60, 8'd70);
      send_blend(Opcode_Chroma, 32'h0000_FF00, 8'd0, 8'd0, 8'd0, 8'd3, 8'd5, 8'd60, 8'd70);
      send_blend(Opcode_Chroma, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
         8'd0, 8'd0);
      send_blend(Opcode_Chroma, 32'h00FF_FF01, 8'd200, 8'd100, 8'd50, 8'd25, 8'd99,
         8'd180, 8'd20);
      drain_results();

      sent = 0;
      while (sent < RandomRequests) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_random_blend();
            sent++;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
            end
            3: begin
               pause($urandom_range(20, 40));
            end
            4: begin
               drain_results();
            end
            default: begin
               pause($urandom_range(1, 6));
            end
         endcase
      end

      drain_results();
      pause(SettleCycles);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_subtitle_coverage_yuv_blend passed");
      end else begin
         $display("tb_subtitle_coverage_yuv_blend failed");
      end
      $finish;
   end

endmodule
